// ----- hw/rtl/est_pkg.sv -----
package est_pkg;

    // Table geometry.
    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
    localparam int DCNT_W      = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int CH_W   = 8;
    localparam int HID_W  = 16;
    localparam int WORD_W = 32;

    // Item kinds.
    localparam logic [1:0] KIND_SUB    = 2'd0;
    localparam logic [1:0] KIND_UNSUB  = 2'd1;
    localparam logic [1:0] KIND_NOTIFY = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ILLEGAL   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register indexes.
    localparam int         CFG_IDX_W   = 2;
    localparam logic [1:0] CFG_LOWEST  = 2'd0;
    localparam logic [1:0] CFG_HIGHEST = 2'd1;
    localparam logic [1:0] CFG_BCAST   = 2'd2;

    // One stored subscription, as kept in the slot memory.
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [HID_W-1:0]  handler;
        logic [WORD_W-1:0] context_word;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Compare results for the slot under inspection.
    typedef struct packed {
        logic same;     // valid, same handler and same channel
        logic unsub;    // valid, same handler, channel matches or broadcast
        logic notify;   // valid, channel matches or broadcast
        logic free;     // slot is not in use
    } t_match;

endpackage

// ----- hw/rtl/est_ram.sv -----
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/est_match.sv -----
module est_match
    import est_pkg::*;
(
    input  t_slot             i_slot,
    input  logic              i_valid,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [HID_W-1:0]  i_handler,
    input  logic              i_all,
    output t_match            o_match
);

    logic hid_eq;
    logic ch_eq;

    // Shared compare unit: one slot against the request per cycle.
    assign hid_eq = (i_slot.handler == i_handler);
    assign ch_eq  = (i_slot.channel == i_channel);

    assign o_match.same   = i_valid && hid_eq && ch_eq;
    assign o_match.unsub  = i_valid && hid_eq && (i_all || ch_eq);
    assign o_match.notify = i_valid && (i_all || ch_eq);
    assign o_match.free   = !i_valid;

endmodule

// ----- hw/rtl/event_subscription_table.sv -----
// Subscription table with SLOT_COUNT slots of channel, handler and context.
// Input channel: i_in_valid with o_in_stall; an item is taken when valid is
// high and stall is low. Kinds are subscribe, unsubscribe, notify and clear.
// Result channel: o_out_valid with i_out_stall; the payload holds while the
// receiver stalls. Every item gives one status result, except a notify with
// matches, which gives one delivery per matching slot with o_last on the final.
// Configuration: i_cfg_valid with o_cfg_ready (always high), i_cfg_index and
// i_cfg_data; write only while the block is idle.
// Scan: a scanning item reads the slot memory one slot per cycle while no
// delivery waits for the output register. A full scan reads every slot
// before the final result is issued and the next item can enter. A
// subscribe or unsubscribe that finds its match in slot k stops early, with
// its result and the next item following that compare. A notify issues each
// delivery when the next matching slot is compared. Clear and an illegal
// channel skip the scan. Each result also waits for the single output
// register, so receiver stalls stretch the scan.
// The table is busy (o_in_stall high) for the whole of one item.
// Reset empties the table by clearing the per-slot valid bits at once and
// loads the channel limits 0 and 254 and broadcast code 255.
module event_subscription_table
    import est_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [HID_W-1:0]      i_handler_id,
    input  logic [WORD_W-1:0]     i_context_req,
    input  logic [WORD_W-1:0]     i_payload,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic                  o_delivery,
    output logic [HID_W-1:0]      o_target_handler,
    output logic [WORD_W-1:0]     o_target_context,
    output logic [WORD_W-1:0]     o_delivered_payload,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CH_W-1:0]       i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Control state.
    logic [1:0]             r_state, n_state;
    logic [CH_W-1:0]        r_cfg_low, r_cfg_high, r_cfg_bcast;
    logic [SLOT_COUNT-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic                   r_free_fnd, n_free_fnd;
    logic                   r_pend, n_pend;
    logic [DCNT_W-1:0]      r_dcnt, n_dcnt;
    logic [1:0]             r_op, n_op;
    logic                   r_out_vld, n_out_vld;

    // Payload state.
    logic [1:0]             r_kind, n_kind;
    logic [CH_W-1:0]        r_req_ch, n_req_ch;
    logic [HID_W-1:0]       r_req_hid, n_req_hid;
    logic [WORD_W-1:0]      r_req_ctx, n_req_ctx;
    logic [WORD_W-1:0]      r_req_pay, n_req_pay;
    logic                   r_all, n_all;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic [IDX_W-1:0]       r_op_idx, n_op_idx;
    logic [1:0]             r_status, n_status;
    logic [HID_W-1:0]       r_pend_hid, n_pend_hid;
    logic [WORD_W-1:0]      r_pend_ctx, n_pend_ctx;
    logic [1:0]             r_out_status, n_out_status;
    logic                   r_out_dlv, n_out_dlv;
    logic [HID_W-1:0]       r_out_hid, n_out_hid;
    logic [WORD_W-1:0]      r_out_ctx, n_out_ctx;
    logic [WORD_W-1:0]      r_out_pay, n_out_pay;
    logic                   r_out_last, n_out_last;

    // Datapath signals.
    t_slot                  rd_slot;
    t_slot                  wr_slot;
    t_match                 m;
    logic                   in_acc;
    logic                   legal;
    logic                   out_free;
    logic                   notify_hit;
    logic                   blocked;
    logic                   scan_go;
    logic                   rd_en;
    logic                   wr_en;
    logic                   early;
    logic                   at_end;
    logic                   free_now;
    logic                   done_go;

    // Slot storage and the shared compare unit.
    est_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_op_idx),
        .i_wr_data (wr_slot),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_slot)
    );

    est_match u_match (
        .i_slot    (rd_slot),
        .i_valid   (r_valid[r_cmp_idx]),
        .i_channel (r_req_ch),
        .i_handler (r_req_hid),
        .i_all     (r_all),
        .o_match   (m)
    );

    // Handshake and scan control terms.
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign legal      = (i_channel >= r_cfg_low) && (i_channel <= r_cfg_high);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign notify_hit = (r_kind == KIND_NOTIFY) && m.notify
                        && (r_dcnt != DCNT_W'(MAX_RESULTS));
    assign blocked    = (r_state == S_SCAN) && r_cmp_vld && notify_hit
                        && r_pend && !out_free;
    assign scan_go    = (r_state == S_SCAN) && !blocked;
    assign rd_en      = scan_go && (r_idx < CNT_W'(SLOT_COUNT));
    assign early      = ((r_kind == KIND_SUB) && m.same)
                        || ((r_kind == KIND_UNSUB) && m.unsub);
    assign at_end     = r_cmp_vld && (early || (r_cmp_idx == IDX_W'(SLOT_COUNT - 1)));
    assign free_now   = (r_kind == KIND_SUB) && m.free && !r_free_fnd;
    assign done_go    = (r_state == S_DONE) && out_free;

    // Table updates take effect as the item's final result is issued.
    assign wr_en   = done_go && (r_op == OP_WRITE);
    assign wr_slot = t_slot'{channel: r_req_ch, handler: r_req_hid, context_word: r_req_ctx};

    // Sequencer next-state logic.
    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_free_fnd   = r_free_fnd;
        n_pend       = r_pend;
        n_dcnt       = r_dcnt;
        n_op         = r_op;
        n_kind       = r_kind;
        n_req_ch     = r_req_ch;
        n_req_hid    = r_req_hid;
        n_req_ctx    = r_req_ctx;
        n_req_pay    = r_req_pay;
        n_all        = r_all;
        n_cmp_idx    = r_cmp_idx;
        n_free_idx   = r_free_idx;
        n_op_idx     = r_op_idx;
        n_status     = r_status;
        n_pend_hid   = r_pend_hid;
        n_pend_ctx   = r_pend_ctx;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_status = r_out_status;
        n_out_dlv    = r_out_dlv;
        n_out_hid    = r_out_hid;
        n_out_ctx    = r_out_ctx;
        n_out_pay    = r_out_pay;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind     = i_kind;
                    n_req_ch   = i_channel;
                    n_req_hid  = i_handler_id;
                    n_req_ctx  = i_context_req;
                    n_req_pay  = i_payload;
                    n_all      = (i_channel == r_cfg_bcast);
                    n_idx      = '0;
                    n_cmp_vld  = 1'b0;
                    n_free_fnd = 1'b0;
                    n_pend     = 1'b0;
                    n_dcnt     = '0;
                    n_op       = OP_NONE;
                    n_status   = ST_OK;
                    unique case (i_kind)
                        KIND_SUB: begin
                            if (legal) begin
                                n_state = S_SCAN;
                            end else begin
                                n_status = ST_ILLEGAL;
                                n_state  = S_DONE;
                            end
                        end
                        KIND_UNSUB: begin
                            n_state = S_SCAN;
                        end
                        KIND_NOTIFY: begin
                            if (legal || (i_channel == r_cfg_bcast)) begin
                                n_state = S_SCAN;
                            end else begin
                                n_status = ST_ILLEGAL;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_op    = OP_CLEAR;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (scan_go) begin
                    // Issue the next slot read and move the compare stage.
                    n_cmp_vld = rd_en;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    if (rd_en) begin
                        n_idx = r_idx + CNT_W'(1);
                    end

                    if (r_cmp_vld) begin
                        // Remember the lowest free slot for a new subscription.
                        if (free_now) begin
                            n_free_fnd = 1'b1;
                            n_free_idx = r_cmp_idx;
                        end

                        // A new delivery pushes out the one held back before it.
                        if (notify_hit) begin
                            if (r_pend) begin
                                n_out_vld    = 1'b1;
                                n_out_status = ST_OK;
                                n_out_dlv    = 1'b1;
                                n_out_hid    = r_pend_hid;
                                n_out_ctx    = r_pend_ctx;
                                n_out_pay    = r_req_pay;
                                n_out_last   = 1'b0;
                            end
                            n_pend     = 1'b1;
                            n_pend_hid = rd_slot.handler;
                            n_pend_ctx = rd_slot.context_word;
                            n_dcnt     = r_dcnt + DCNT_W'(1);
                        end

                        // Decide the outcome at a hit or after the last slot.
                        if (at_end) begin
                            n_state = S_DONE;
                            case (r_kind)
                                KIND_SUB: begin
                                    if (m.same) begin
                                        n_op     = OP_WRITE;
                                        n_op_idx = r_cmp_idx;
                                    end else if (free_now) begin
                                        n_op     = OP_WRITE;
                                        n_op_idx = r_cmp_idx;
                                    end else if (r_free_fnd) begin
                                        n_op     = OP_WRITE;
                                        n_op_idx = r_free_idx;
                                    end else begin
                                        n_status = ST_EXHAUSTED;
                                    end
                                end
                                KIND_UNSUB: begin
                                    if (m.unsub) begin
                                        n_op     = OP_FREE;
                                        n_op_idx = r_cmp_idx;
                                    end else begin
                                        n_status = ST_NOT_FOUND;
                                    end
                                end
                                default: begin
                                    n_status = ST_OK;
                                end
                            endcase
                        end
                    end
                end
            end

            S_DONE: begin
                if (done_go) begin
                    // Final result: the held delivery, or a status.
                    n_out_vld = 1'b1;
                    n_out_pay = '0;
                    if ((r_kind == KIND_NOTIFY) && r_pend) begin
                        n_out_status = ST_OK;
                        n_out_dlv    = 1'b1;
                        n_out_hid    = r_pend_hid;
                        n_out_ctx    = r_pend_ctx;
                        n_out_pay    = r_req_pay;
                    end else begin
                        n_out_status = r_status;
                        n_out_dlv    = 1'b0;
                        n_out_hid    = '0;
                        n_out_ctx    = '0;
                    end
                    n_out_last = 1'b1;

                    unique case (r_op)
                        OP_WRITE: n_valid[r_op_idx] = 1'b1;
                        OP_FREE:  n_valid[r_op_idx] = 1'b0;
                        OP_CLEAR: n_valid = '0;
                        default:  n_valid = r_valid;
                    endcase
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_free_fnd  <= 1'b0;
            r_pend      <= 1'b0;
            r_dcnt      <= '0;
            r_op        <= OP_NONE;
            r_out_vld   <= 1'b0;
            r_cfg_low   <= 8'd0;
            r_cfg_high  <= 8'd254;
            r_cfg_bcast <= 8'd255;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_free_fnd <= n_free_fnd;
            r_pend     <= n_pend;
            r_dcnt     <= n_dcnt;
            r_op       <= n_op;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LOWEST:  r_cfg_low   <= i_cfg_data;
                    CFG_HIGHEST: r_cfg_high  <= i_cfg_data;
                    CFG_BCAST:   r_cfg_bcast <= i_cfg_data;
                    default:     r_cfg_low   <= r_cfg_low;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_req_ch     <= n_req_ch;
        r_req_hid    <= n_req_hid;
        r_req_ctx    <= n_req_ctx;
        r_req_pay    <= n_req_pay;
        r_all        <= n_all;
        r_cmp_idx    <= n_cmp_idx;
        r_free_idx   <= n_free_idx;
        r_op_idx     <= n_op_idx;
        r_status     <= n_status;
        r_pend_hid   <= n_pend_hid;
        r_pend_ctx   <= n_pend_ctx;
        r_out_status <= n_out_status;
        r_out_dlv    <= n_out_dlv;
        r_out_hid    <= n_out_hid;
        r_out_ctx    <= n_out_ctx;
        r_out_pay    <= n_out_pay;
        r_out_last   <= n_out_last;
    end

    // Result ports.
    assign o_out_valid         = r_out_vld;
    assign o_status            = r_out_status;
    assign o_delivery          = r_out_dlv;
    assign o_target_handler    = r_out_hid;
    assign o_target_context    = r_out_ctx;
    assign o_delivered_payload = r_out_pay;
    assign o_last              = r_out_last;

endmodule

// ----- dv/tb_event_subscription_table.sv -----
`timescale 1ns / 100ps

module tb_event_subscription_table;

    import est_pkg::*;

    // Longest run of cycles with no handshake on any channel before giving up.
    localparam int QUIET_LIMIT = 4000;
    // Cycles allowed for the block to settle once every result has arrived.
    localparam int SETTLE_CYCLES = SLOT_COUNT + 8;

    typedef struct packed {
        logic [1:0]        status;
        logic              delivery;
        logic [HID_W-1:0]  handler;
        logic [WORD_W-1:0] context_word;
        logic [WORD_W-1:0] payload;
        logic              last;
    } t_table_result;

    // Ports of the block.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_kind = KIND_SUB;
    logic [CH_W-1:0]      i_channel = '0;
    logic [HID_W-1:0]     i_handler_id = '0;
    logic [WORD_W-1:0]    i_context_req = '0;
    logic [WORD_W-1:0]    i_payload = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic                 o_delivery;
    logic [HID_W-1:0]     o_target_handler;
    logic [WORD_W-1:0]    o_target_context;
    logic [WORD_W-1:0]    o_delivered_payload;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LOWEST;
    logic [CH_W-1:0]      i_cfg_data = '0;

    // Shadow copy of the subscription table and its registers.
    bit                   tbl_valid [SLOT_COUNT];
    logic [CH_W-1:0]      tbl_channel [SLOT_COUNT];
    logic [HID_W-1:0]     tbl_handler [SLOT_COUNT];
    logic [WORD_W-1:0]    tbl_context [SLOT_COUNT];
    logic [CH_W-1:0]      cfg_lowest = 8'd0;
    logic [CH_W-1:0]      cfg_highest = 8'd254;
    logic [CH_W-1:0]      cfg_bcast = 8'd255;

    // Results the block still owes, oldest first.
    t_table_result        owed_results [$];

    // Value pools that keep random items hitting stored subscriptions.
    logic [CH_W-1:0]      chan_pool [3];
    logic [HID_W-1:0]     handler_pool [6];

    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    int                   hold_cycles = 0;
    bit                   burst_mode = 1'b0;

    event_subscription_table DUT (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run when no channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void flag_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endfunction

    function automatic string fmt_result(t_table_result r);
        return $sformatf("status=%0d delivery=%0b handler=%h context=%h payload=%h last=%0b",
                         r.status, r.delivery, r.handler, r.context_word, r.payload, r.last);
    endfunction

    function automatic bit chan_legal(logic [CH_W-1:0] ch);
        return (ch >= cfg_lowest) && (ch <= cfg_highest);
    endfunction

    function automatic void owe_status(logic [1:0] st);
        t_table_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        owed_results.push_back(r);
    endfunction

    // Apply one accepted item to the shadow table and queue what it produces.
    function automatic void table_apply(logic [1:0] kind, logic [CH_W-1:0] ch,
                                        logic [HID_W-1:0] hid, logic [WORD_W-1:0] ctx,
                                        logic [WORD_W-1:0] pay);
        int free_idx;
        int total;
        int n;
        bit done;
        bit all;
        t_table_result r;
        free_idx = -1;
        total = 0;
        n = 0;
        done = 1'b0;
        all = (ch == cfg_bcast);
        case (kind)
            KIND_SUB: begin
                if (!chan_legal(ch)) begin
                    owe_status(ST_ILLEGAL);
                end else begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!done && tbl_valid[i] && tbl_handler[i] == hid &&
                            tbl_channel[i] == ch) begin
                            tbl_context[i] = ctx;
                            done = 1'b1;
                        end
                        if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
                    end
                    if (done) begin
                        owe_status(ST_OK);
                    end else if (free_idx < 0) begin
                        owe_status(ST_EXHAUSTED);
                    end else begin
                        tbl_valid[free_idx] = 1'b1;
                        tbl_channel[free_idx] = ch;
                        tbl_handler[free_idx] = hid;
                        tbl_context[free_idx] = ctx;
                        owe_status(ST_OK);
                    end
                end
            end
            KIND_UNSUB: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!done && tbl_valid[i] && tbl_handler[i] == hid &&
                        (all || tbl_channel[i] == ch)) begin
                        tbl_valid[i] = 1'b0;
                        done = 1'b1;
                    end
                end
                owe_status(done ? ST_OK : ST_NOT_FOUND);
            end
            KIND_NOTIFY: begin
                if (!all && !chan_legal(ch)) begin
                    owe_status(ST_ILLEGAL);
                end else begin
                    // Count matches first so the final delivery can be marked.
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (tbl_valid[i] && (all || tbl_channel[i] == ch)) total++;
                    end
                    if (total > MAX_RESULTS) total = MAX_RESULTS;
                    if (total == 0) begin
                        owe_status(ST_OK);
                    end else begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (n < total && tbl_valid[i] && (all || tbl_channel[i] == ch)) begin
                                n++;
                                r.status = ST_OK;
                                r.delivery = 1'b1;
                                r.handler = tbl_handler[i];
                                r.context_word = tbl_context[i];
                                r.payload = pay;
                                r.last = (n == total);
                                owed_results.push_back(r);
                            end
                        end
                    end
                end
            end
            default: begin
                for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
                owe_status(ST_OK);
            end
        endcase
    endfunction

    function automatic int draw_gap();
        if (burst_mode) return 0;
        return $urandom_range(0, 18);
    endfunction

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(logic [1:0] kind, logic [CH_W-1:0] ch, logic [HID_W-1:0] hid,
                             logic [WORD_W-1:0] ctx, logic [WORD_W-1:0] pay);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_channel <= ch;
        i_handler_id <= hid;
        i_context_req <= ctx;
        i_payload <= pay;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        table_apply(kind, ch, hid, ctx, pay);
    endtask

    // Pick a random occupied slot, or -1 when the table is empty.
    function automatic int pick_used_slot();
        int start;
        int idx;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (start + k) % SLOT_COUNT;
            if (tbl_valid[idx]) return idx;
        end
        return -1;
    endfunction

    // Mostly well-formed traffic on pooled channels and handlers, some noise.
    task automatic send_random_item();
        int sel;
        int slot;
        logic [1:0] kind;
        logic [CH_W-1:0] ch;
        logic [HID_W-1:0] hid;
        sel = $urandom_range(0, 99);
        if (sel < 42) kind = KIND_SUB;
        else if (sel < 64) kind = KIND_UNSUB;
        else if (sel < 97) kind = KIND_NOTIFY;
        else kind = KIND_CLEAR;
        sel = $urandom_range(0, 99);
        if (sel < 55) ch = chan_pool[$urandom_range(0, 2)];
        else if (sel < 70) ch = cfg_bcast;
        else ch = CH_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7) hid = handler_pool[$urandom_range(0, 5)];
        else hid = HID_W'($urandom_range(1, 65535));
        slot = pick_used_slot();
        if (slot >= 0 && $urandom_range(0, 3) == 0) begin
            hid = tbl_handler[slot];
            if (kind != KIND_UNSUB || $urandom_range(0, 1) == 0) ch = tbl_channel[slot];
        end
        send_item(kind, ch, hid, $urandom, $urandom);
    endtask

    // Write one register; the caller lowers the valid after its last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_LOWEST: cfg_lowest = data;
            CFG_HIGHEST: cfg_highest = data;
            CFG_BCAST: cfg_bcast = data;
            default: ;
        endcase
    endtask

    // Wait until every owed result has come, then let the block settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random stalls, an occasional long hold, and the check itself.
    initial begin : result_sink
        int wait_n;
        t_table_result got;
        t_table_result want;
        forever begin
            if (hold_cycles > 0) begin
                wait_n = hold_cycles;
                hold_cycles = 0;
            end else begin
                wait_n = draw_gap();
            end
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            got = '{o_status, o_delivery, o_target_handler, o_target_context,
                    o_delivered_payload, o_last};
            if (owed_results.size() == 0) begin
                flag_failure({"unexpected result ", fmt_result(got)});
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status || got.delivery !== want.delivery ||
                    got.handler !== want.handler || got.context_word !== want.context_word ||
                    got.payload !== want.payload || got.last !== want.last) begin
                    flag_failure($sformatf("expected %s, got %s",
                                           fmt_result(want), fmt_result(got)));
                end
            end
        end
    end

    // Field extremes and the subscribe, notify and unsubscribe kinds under the reset settings.
    task automatic test_basic_ops();
        send_item(KIND_SUB, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(KIND_SUB, 8'd254, 16'h0001, 32'h0, 32'hFFFF_FFFF);
        // Broadcast code is outside the legal range, so subscribe rejects it.
        send_item(KIND_SUB, 8'd255, 16'h1234, 32'h1111_2222, 32'h0);
        // Same handler and channel only replaces the stored context.
        send_item(KIND_SUB, 8'd0, 16'hFFFF, 32'h5A5A_5A5A, 32'h0);
        send_item(KIND_NOTIFY, 8'd0, 16'h0001, 32'h0, 32'hFFFF_FFFF);
        send_item(KIND_NOTIFY, 8'd255, 16'h0001, 32'h0, 32'h0);
        send_item(KIND_NOTIFY, 8'd100, 16'h0001, 32'h0, 32'hA5A5_A5A5);
        // Unsubscribe with the broadcast code matches any channel.
        send_item(KIND_UNSUB, 8'd255, 16'h0001, 32'h0, 32'h0);
        send_item(KIND_UNSUB, 8'd255, 16'h0001, 32'h0, 32'h0);
        send_item(KIND_UNSUB, 8'd7, 16'hFFFF, 32'h0, 32'h0);
    endtask

    // Fill every slot, overflow the table, notify all of them, clear, then notify the empty table.
    task automatic test_table_full();
        for (int i = 1; i < SLOT_COUNT; i++) begin
            send_item(KIND_SUB, CH_W'(i * 16), HID_W'(16'h8000 | i), $urandom, $urandom);
        end
        send_item(KIND_SUB, 8'd3, 16'h0002, 32'hDEAD_BEEF, 32'h0);
        send_item(KIND_NOTIFY, 8'd255, 16'h0001, 32'h0, $urandom);
        send_item(KIND_CLEAR, 8'd0, 16'h0001, 32'h0, 32'h0);
        send_item(KIND_NOTIFY, 8'd255, 16'h0001, 32'h0, $urandom);
    endtask

    // One register setting followed by random traffic, with a burst window.
    task automatic test_config_phase(logic [CH_W-1:0] lo, logic [CH_W-1:0] hi,
                                     logic [CH_W-1:0] bc, int count);
        drain_results();
        cfg_write(CFG_LOWEST, lo);
        cfg_write(CFG_HIGHEST, hi);
        cfg_write(CFG_BCAST, bc);
        i_cfg_valid <= 1'b0;
        chan_pool[0] = lo;
        chan_pool[1] = hi;
        chan_pool[2] = (lo <= hi) ? CH_W'($urandom_range(hi, lo)) : CH_W'($urandom_range(0, 255));
        for (int k = 0; k < 6; k++) handler_pool[k] = HID_W'($urandom_range(1, 65535));
        for (int k = 0; k < count; k++) begin
            burst_mode = (k >= 10 && k < 26);
            send_random_item();
        end
        burst_mode = 1'b0;
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_cycles = 300;
        burst_mode = 1'b1;
        repeat (20) send_random_item();
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ops();
        test_table_full();
        test_config_phase(8'd0, 8'd254, 8'd255, 55);
        test_config_phase(8'd0, 8'd255, 8'd255, 55);
        test_backpressure();
        test_config_phase(8'd10, 8'd20, 8'd15, 55);
        test_config_phase(8'd200, 8'd100, 8'd7, 55);
        test_config_phase(8'd255, 8'd255, 8'd0, 55);
        test_config_phase(8'd0, 8'd0, 8'd128, 55);
        drain_results();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- event_subscription_table.f -----
hw/rtl/est_pkg.sv
hw/rtl/est_ram.sv
hw/rtl/est_match.sv
hw/rtl/event_subscription_table.sv
dv/tb_event_subscription_table.sv
